// ===== hw/rtl/rqfi_pkg.sv =====
// rqfi_pkg: shared types and constants for the ring queue with front insert
// holds opcode and status codes, transaction structs and parameter defaults
// no dependencies
package rqfi_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 16;
  localparam int ENTRY_W        = 16;
  localparam int FILL_W         = 4;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_PEEK_FRONT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [ENTRY_W-1:0] entry_data;
  } cmd_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] read_data;
    logic [1:0]         status;
    logic [FILL_W-1:0]  fill_count;
  } rsp_t;

  // controls from pointer logic to the slot store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

endpackage

// ===== hw/rtl/rqfi_ctrl.sv =====
// rqfi_ctrl: head/tail/count registers, status decode and result register
// depends on rqfi_pkg
module rqfi_ctrl #(
  parameter int DEPTH = rqfi_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [1:0]                opcode,
  output rqfi_pkg::store_ctl_t      store_ctl,
  output logic [$clog2(DEPTH)-1:0]  wr_addr,
  output logic [$clog2(DEPTH)-1:0]  rd_addr,
  output logic                      done,
  output logic [1:0]                status,
  output logic [rqfi_pkg::FILL_W-1:0] fill_count
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH);
  localparam int FILL_W = rqfi_pkg::FILL_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH - 1);

  logic [PTR_W-1:0] head, head_next, tail, tail_next;
  logic [CNT_W-1:0] count, count_next;
  logic [PTR_W-1:0] head_inc, head_dec, tail_inc;
  rqfi_pkg::status_t status_next;
  logic full, empty;

  assign head_inc = (head == PTR_LAST) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? PTR_LAST : head - 1'b1;
  assign tail_inc = (tail == PTR_LAST) ? '0 : tail + 1'b1;
  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign rd_addr  = head;

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    status_next = rqfi_pkg::ST_OK;
    store_ctl   = '0;
    wr_addr     = tail_inc;
    case (rqfi_pkg::op_t'(opcode))
      rqfi_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status_next = rqfi_pkg::ST_FULL;
        end else begin
          store_ctl.wr_en = accept;
          tail_next       = tail_inc;
          count_next      = count + 1'b1;
        end
      end
      rqfi_pkg::OP_PUSH_FRONT: begin
        wr_addr = head_dec;
        if (full) begin
          status_next = rqfi_pkg::ST_FULL;
        end else begin
          store_ctl.wr_en = accept;
          head_next       = head_dec;
          count_next      = count + 1'b1;
        end
      end
      rqfi_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status_next = rqfi_pkg::ST_EMPTY;
        end else begin
          store_ctl.rd_en = accept;
          head_next       = head_inc;
          count_next      = count - 1'b1;
        end
      end
      rqfi_pkg::OP_PEEK_FRONT: begin
        if (empty) begin
          status_next = rqfi_pkg::ST_EMPTY;
        end else begin
          store_ctl.rd_en = accept;
        end
      end
      default: begin
        status_next = rqfi_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= PTR_LAST;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
      end
    end
  end

  // result payload, no reset needed; count is cut or widened to the field
  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= status_next;
      fill_count <= FILL_W'(count_next);
    end
  end

endmodule

// ===== hw/rtl/rqfi_store.sv =====
// rqfi_store: slot memory with one write port and a registered read port
// depends on rqfi_pkg
module rqfi_store #(
  parameter int DEPTH  = rqfi_pkg::DEPTH_DEF,
  parameter int KEEP_W = rqfi_pkg::ENTRY_W
) (
  input  logic                     clk,
  input  rqfi_pkg::store_ctl_t     store_ctl,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [KEEP_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [KEEP_W-1:0]        rd_data
);

  logic [KEEP_W-1:0] mem [DEPTH];
  logic [KEEP_W-1:0] rd_q;
  logic              rd_keep;

  always_ff @(posedge clk) begin
    if (store_ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_keep <= store_ctl.rd_en;
    if (store_ctl.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // pushes and refused reads show zero
  assign rd_data = rd_keep ? rd_q : '0;

endmodule

// ===== hw/rtl/ring_queue_with_front_insert_unit.sv =====
// ring_queue_with_front_insert_unit: top level of the circular handle queue
// instantiates rqfi_ctrl and rqfi_store; types from rqfi_pkg
//
//  channel   handshake            payload       direction
//  command   start / busy         cmd (cmd_t)   in
//  result    done (strobe only)   rsp (rsp_t)   out
//
// one transaction is taken per cycle while busy is low; its result strobes on done the cycle after
// the command edge, so throughput is one per cycle
// slot memory is read at the command edge into a registered read port
// busy is high only while rst is asserted; no clearing pass, slots hold junk until pushed
// the receiver cannot stall, so every result is valid on rsp only in the cycle done marks it
module ring_queue_with_front_insert_unit #(
  parameter int DEPTH      = rqfi_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rqfi_pkg::DATA_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  rqfi_pkg::cmd_t cmd,
  output logic           done,
  output rqfi_pkg::rsp_t rsp
);

  // only the low bits of a handle that fit both the entry field and DATA_WIDTH are kept
  localparam int KEEP_W = (DATA_WIDTH < rqfi_pkg::ENTRY_W) ? DATA_WIDTH : rqfi_pkg::ENTRY_W;
  localparam int PTR_W  = $clog2(DEPTH);

  logic                          accept;
  rqfi_pkg::store_ctl_t          store_ctl;
  logic [PTR_W-1:0]              wr_addr, rd_addr;
  logic [KEEP_W-1:0]             rd_data;
  logic [1:0]                    status;
  logic [rqfi_pkg::FILL_W-1:0]   fill_count;
  logic [rqfi_pkg::ENTRY_W-1:0]  read_data;

  assign busy   = rst;
  assign accept = start & ~busy;

  rqfi_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .opcode     (cmd.opcode),
    .store_ctl  (store_ctl),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .done       (done),
    .status     (status),
    .fill_count (fill_count)
  );

  rqfi_store #(
    .DEPTH  (DEPTH),
    .KEEP_W (KEEP_W)
  ) u_store (
    .clk       (clk),
    .store_ctl (store_ctl),
    .wr_addr   (wr_addr),
    .wr_data   (cmd.entry_data[KEEP_W-1:0]),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // widen stored handle back to the entry field
  generate
    if (KEEP_W < rqfi_pkg::ENTRY_W) begin : g_widen
      assign read_data = {{(rqfi_pkg::ENTRY_W - KEEP_W){1'b0}}, rd_data};
    end else begin : g_full
      assign read_data = rd_data;
    end
  endgenerate

  assign rsp.read_data  = read_data;
  assign rsp.status     = status;
  assign rsp.fill_count = fill_count;

endmodule

// ===== verif/testbench.sv =====
// testbench for ring_queue_with_front_insert_unit: directed table, then random commands
// with bursty issue; results are checked against typed-in values or a behavioral queue predictor
// depends on rqfi_pkg and the ring_queue_with_front_insert_unit rtl
module testbench;

  localparam int QDEPTH      = rqfi_pkg::DEPTH_DEF;
  localparam int EW          = rqfi_pkg::ENTRY_W;
  localparam int FW          = rqfi_pkg::FILL_W;
  localparam int RAND_CMDS   = 2000;
  localparam int STALL_LIMIT = 2000;

  // directed stimulus row: a typed-in result is used where it is obvious,
  // otherwise the predictor supplies it
  typedef struct {
    rqfi_pkg::op_t  op;
    logic [EW-1:0]  data;
    int             reps;
    bit             rnd_data;
    bit             typed;
    rqfi_pkg::rsp_t want;
  } dir_row_t;

  // random mix phases: lean toward full, toward empty, or neither
  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  rqfi_pkg::cmd_t cmd = '0;
  logic done;
  rqfi_pkg::rsp_t rsp;

  // side info that travels with the command being offered
  bit             cur_typed = 1'b0;
  rqfi_pkg::rsp_t cur_want = '0;

  // predictor state
  logic [EW-1:0] slot_mem [QDEPTH];
  int head_ptr = 0;
  int tail_ptr = QDEPTH - 1;
  int held = 0;

  rqfi_pkg::rsp_t pending_q [$];
  int err_count = 0;
  int n_cmds = 0;
  int n_results = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_pauses = 0;
  int stall_cycles = 0;

  always #4 clk = ~clk;

  ring_queue_with_front_insert_unit dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .rsp   (rsp)
  );

  // one queue operation on the predictor state, returns the expected result
  function automatic rqfi_pkg::rsp_t queue_step(rqfi_pkg::cmd_t c);
    rqfi_pkg::rsp_t r;
    r = '0;
    r.status = rqfi_pkg::ST_OK;
    case (rqfi_pkg::op_t'(c.opcode))
      rqfi_pkg::OP_PUSH_BACK, rqfi_pkg::OP_PUSH_FRONT: begin
        if (held >= QDEPTH - 1) begin
          r.status = rqfi_pkg::ST_FULL;
        end else if (rqfi_pkg::op_t'(c.opcode) == rqfi_pkg::OP_PUSH_BACK) begin
          tail_ptr = (tail_ptr + 1) % QDEPTH;
          slot_mem[tail_ptr] = c.entry_data;
          held++;
        end else begin
          head_ptr = (head_ptr + QDEPTH - 1) % QDEPTH;
          slot_mem[head_ptr] = c.entry_data;
          held++;
        end
      end
      default: begin
        if (held == 0) begin
          r.status = rqfi_pkg::ST_EMPTY;
        end else begin
          r.read_data = slot_mem[head_ptr];
          if (rqfi_pkg::op_t'(c.opcode) == rqfi_pkg::OP_POP_FRONT) begin
            head_ptr = (head_ptr + 1) % QDEPTH;
            held--;
          end
        end
      end
    endcase
    r.fill_count = held[FW-1:0];
    return r;
  endfunction

  // monitor: check results, record accepted commands, watchdog
  always @(posedge clk) begin
    rqfi_pkg::rsp_t want;
    rqfi_pkg::rsp_t pred;
    bit   moved;
    moved = 1'b0;
    if (!rst && done) begin
      moved = 1'b1;
      n_results++;
      if (pending_q.size() == 0) begin
        $error("result with no pending transaction: %h", rsp);
        err_count++;
      end else begin
        want = pending_q.pop_front();
        if (rsp.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, rsp.read_data);
          err_count++;
        end
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          err_count++;
        end
        if (rsp.fill_count !== want.fill_count) begin
          $error("fill_count: expected %0d, got %0d", want.fill_count, rsp.fill_count);
          err_count++;
        end
      end
    end
    // a command is taken when start is high and busy is low
    if (!rst && start && !busy) begin
      moved = 1'b1;
      n_cmds++;
      pred = queue_step(cmd);
      if (pred.status == rqfi_pkg::ST_FULL) n_full++;
      if (pred.status == rqfi_pkg::ST_EMPTY) n_empty++;
      pending_q.push_back(cur_typed ? cur_want : pred);
    end
    // watchdog on cycles with no transaction on either side
    if (moved) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // offer one command and hold it until taken
  task automatic issue_cmd(input rqfi_pkg::op_t op, input logic [EW-1:0] data,
                           input bit typed, input rqfi_pkg::rsp_t want);
    @(negedge clk);
    start = 1'b1;
    cmd.opcode = op;
    cmd.entry_data = data;
    cur_typed = typed;
    cur_want = want;
    do @(posedge clk); while (busy);
  endtask

  // stop issuing until every outstanding result has come back
  task automatic pause_until_drained();
    @(negedge clk);
    start = 1'b0;
    n_pauses++;
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    dir_row_t plan [$];
    logic [EW-1:0] data;
    rqfi_pkg::op_t op;
    mix_t mix;
    int   mix_left;
    int   burst_left;
    int   gap;
    int   thr;

    // empty queue: peek and pop both report empty
    plan.push_back('{rqfi_pkg::OP_PEEK_FRONT, 16'h0000, 1, 1'b0, 1'b1,
                     '{16'h0000, rqfi_pkg::ST_EMPTY, 4'd0}});
    plan.push_back('{rqfi_pkg::OP_POP_FRONT, 16'h0000, 1, 1'b0, 1'b1,
                     '{16'h0000, rqfi_pkg::ST_EMPTY, 4'd0}});
    // data extremes through both push kinds
    plan.push_back('{rqfi_pkg::OP_PUSH_BACK, 16'hffff, 1, 1'b0, 1'b1,
                     '{16'h0000, rqfi_pkg::ST_OK, 4'd1}});
    plan.push_back('{rqfi_pkg::OP_PUSH_FRONT, 16'h0000, 1, 1'b0, 1'b1,
                     '{16'h0000, rqfi_pkg::ST_OK, 4'd2}});
    // peek leaves the queue alone, pops come out front-inserted first
    plan.push_back('{rqfi_pkg::OP_PEEK_FRONT, 16'h1111, 1, 1'b0, 1'b1,
                     '{16'h0000, rqfi_pkg::ST_OK, 4'd2}});
    plan.push_back('{rqfi_pkg::OP_POP_FRONT, 16'h2222, 1, 1'b0, 1'b1,
                     '{16'h0000, rqfi_pkg::ST_OK, 4'd1}});
    plan.push_back('{rqfi_pkg::OP_POP_FRONT, 16'h3333, 1, 1'b0, 1'b1,
                     '{16'hffff, rqfi_pkg::ST_OK, 4'd0}});
    // fill to capacity, wrapping head backward
    plan.push_back('{rqfi_pkg::OP_PUSH_FRONT, 16'ha5a5, 1, 1'b0, 1'b1,
                     '{16'h0000, rqfi_pkg::ST_OK, 4'd1}});
    plan.push_back('{rqfi_pkg::OP_PUSH_BACK, 16'h0000, 13, 1'b1, 1'b0, '0});
    plan.push_back('{rqfi_pkg::OP_PUSH_FRONT, 16'h5a5a, 1, 1'b0, 1'b1,
                     '{16'h0000, rqfi_pkg::ST_OK, 4'd15}});
    // full queue refuses both push kinds
    plan.push_back('{rqfi_pkg::OP_PUSH_BACK, 16'h1234, 1, 1'b0, 1'b1,
                     '{16'h0000, rqfi_pkg::ST_FULL, 4'd15}});
    plan.push_back('{rqfi_pkg::OP_PUSH_FRONT, 16'h4321, 1, 1'b0, 1'b1,
                     '{16'h0000, rqfi_pkg::ST_FULL, 4'd15}});
    plan.push_back('{rqfi_pkg::OP_PEEK_FRONT, 16'h0000, 1, 1'b0, 1'b1,
                     '{16'h5a5a, rqfi_pkg::ST_OK, 4'd15}});

    repeat (12) @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      repeat (plan[i].reps) begin
        data = plan[i].rnd_data ? EW'($urandom) : plan[i].data;
        issue_cmd(plan[i].op, data, plan[i].typed, plan[i].want);
      end
    end
    pause_until_drained();

    // random part: phases that push toward full or empty, bursty issue
    mix = MIX_EVEN;
    mix_left = 0;
    burst_left = $urandom_range(1, 40);
    for (int n = 0; n < RAND_CMDS; n++) begin
      if (mix_left == 0) begin
        mix = mix_t'($urandom_range(2));
        mix_left = $urandom_range(10, 60);
      end
      mix_left--;
      thr = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 25 : 50;
      if ($urandom_range(99) < thr)
        op = $urandom_range(1) ? rqfi_pkg::OP_PUSH_FRONT : rqfi_pkg::OP_PUSH_BACK;
      else
        op = ($urandom_range(2) == 0) ? rqfi_pkg::OP_PEEK_FRONT : rqfi_pkg::OP_POP_FRONT;
      case ($urandom_range(7))
        0: data = '0;
        1: data = '1;
        default: data = EW'($urandom);
      endcase
      issue_cmd(op, data, 1'b0, '0);

      if ($urandom_range(399) == 0) begin
        pause_until_drained();
      end
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(4) == 0) ? $urandom_range(1, 20) : $urandom_range(0, 3);
        if (gap > 0) begin
          @(negedge clk);
          start = 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end

    // drain, then idle on to catch any stray strobe
    @(negedge clk);
    start = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);

    $display("ran %0d commands, %0d results checked, %0d refused full, %0d empty reads",
             n_cmds, n_results, n_full, n_empty);
    $display("issue paused until drained %0d times", n_pauses);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== ring_queue_with_front_insert_unit.f =====
hw/rtl/rqfi_pkg.sv
hw/rtl/rqfi_ctrl.sv
hw/rtl/rqfi_store.sv
hw/rtl/ring_queue_with_front_insert_unit.sv
verif/testbench.sv
